@@ hw/rtl/dsu_pkg.sv @@
package dsu_pkg;

    // Field widths of one transaction
    localparam int OP_W    = 2;
    localparam int NODE_W  = 10;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 11;

    // Default table size
    localparam int MAX_VERTICES_DEF = 1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MAKE_SET = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND     = 2'd1;
    localparam logic [OP_W-1:0] OP_UNION    = 2'd2;

    // Saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RANK_W-1:0]  RANK_MAX  = '1;

    // Table access issued by the sequencer, one read and one write per table
    typedef struct packed {
        logic [NODE_W-1:0] p_raddr;
        logic              p_we;
        logic [NODE_W-1:0] p_waddr;
        logic [NODE_W-1:0] p_wdata;
        logic [NODE_W-1:0] r_raddr;
        logic              r_we;
        logic [NODE_W-1:0] r_waddr;
        logic [RANK_W-1:0] r_wdata;
    } tbl_req_t;

    // Registered read data, valid in the cycle after the address
    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [RANK_W-1:0] rank;
    } tbl_rsp_t;

    // One finished result
    typedef struct packed {
        logic [COUNT_W-1:0] set_count;
        logic               merged;
        logic [NODE_W-1:0]  root_b;
        logic [NODE_W-1:0]  root_a;
    } dsu_res_t;

endpackage

@@ hw/rtl/dsu_table.sv @@
module dsu_table
    import dsu_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic     clk,
    input  tbl_req_t req,
    output tbl_rsp_t rsp
);

    // Only vertices that fit the node field can ever be addressed
    localparam int DEPTH = (MAX_VERTICES < (1 << NODE_W)) ? MAX_VERTICES : (1 << NODE_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [NODE_W-1:0] parent_mem [DEPTH];
    logic [RANK_W-1:0] rank_mem   [DEPTH];
    logic [NODE_W-1:0] parent_rd_reg;
    logic [RANK_W-1:0] rank_rd_reg;

    // Parent pointers: one write, one registered read (old data on a collision)
    always_ff @(posedge clk)
    begin
        if (req.p_we)
        begin
            parent_mem[AW'(req.p_waddr)] <= req.p_wdata;
        end
        parent_rd_reg <= parent_mem[AW'(req.p_raddr)];
    end

    // Ranks: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (req.r_we)
        begin
            rank_mem[AW'(req.r_waddr)] <= req.r_wdata;
        end
        rank_rd_reg <= rank_mem[AW'(req.r_raddr)];
    end

    assign rsp.parent = parent_rd_reg;
    assign rsp.rank   = rank_rd_reg;

endmodule

@@ hw/rtl/dsu_seq.sv @@
module dsu_seq
    import dsu_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_opcode,
    input  logic [NODE_W-1:0] in_node_a,
    input  logic [NODE_W-1:0] in_node_b,
    output logic              res_valid,
    input  logic              res_ready,
    output dsu_res_t          res,
    output tbl_req_t          tbl_req,
    input  tbl_rsp_t          tbl_rsp
);

    localparam int DEPTH = (MAX_VERTICES < (1 << NODE_W)) ? MAX_VERTICES : (1 << NODE_W);
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SW-1:0] STEP_LAST = SW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_COMP_START,
        S_COMP_CHK,
        S_RANK_A,
        S_RANK_B,
        S_RANK_C,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [NODE_W-1:0]  b_reg, b_next;
    logic [NODE_W-1:0]  v_reg, v_next;
    logic [NODE_W-1:0]  root_reg, root_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [NODE_W-1:0]  xr_reg, xr_next;
    logic               phase_reg, phase_next;
    logic [SW-1:0]      step_reg, step_next;
    logic [RANK_W-1:0]  rx_reg, rx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [NODE_W-1:0]  ra_reg, ra_next;
    logic [NODE_W-1:0]  rb_reg, rb_next;
    logic               merged_reg, merged_next;

    // Sequencer: pointer chase, compression and linking over the shared table ports
    always_comb
    begin
        logic              in_range;
        logic              find_done;
        logic [NODE_W-1:0] p;
        logic [RANK_W-1:0] ry;

        state_next  = state_reg;
        op_next     = op_reg;
        b_next      = b_reg;
        v_next      = v_reg;
        root_next   = root_reg;
        cur_next    = cur_reg;
        xr_next     = xr_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        rx_next     = rx_reg;
        count_next  = count_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        merged_next = merged_reg;
        tbl_req     = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        find_done   = 1'b0;
        p           = tbl_rsp.parent;
        ry          = tbl_rsp.rank;
        in_range    = (int'(in_node_a) < MAX_VERTICES) &&
                      ((in_opcode != OP_UNION) || (int'(in_node_b) < MAX_VERTICES));

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_opcode;
                    b_next      = in_node_b;
                    ra_next     = '0;
                    rb_next     = '0;
                    merged_next = 1'b0;
                    state_next  = S_FINISH;
                    if (in_range && (in_opcode == OP_MAKE_SET))
                    begin
                        // Make the vertex its own root with rank zero
                        tbl_req.p_we    = 1'b1;
                        tbl_req.p_waddr = in_node_a;
                        tbl_req.p_wdata = in_node_a;
                        tbl_req.r_we    = 1'b1;
                        tbl_req.r_waddr = in_node_a;
                        tbl_req.r_wdata = '0;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        ra_next = in_node_a;
                    end
                    else if (in_range && (in_opcode inside {OP_FIND, OP_UNION}))
                    begin
                        v_next     = in_node_a;
                        root_next  = in_node_a;
                        phase_next = 1'b0;
                        step_next  = '0;
                        state_next = S_WALK_RD;
                    end
                end
            end

            S_WALK_RD:
            begin
                tbl_req.p_raddr = root_reg;
                state_next      = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                // Stop at a self-pointing node or at the step limit, else follow the pointer
                if ((p == root_reg) || (step_reg == STEP_LAST))
                begin
                    cur_next   = v_reg;
                    step_next  = '0;
                    state_next = S_COMP_START;
                end
                else
                begin
                    root_next       = p;
                    step_next       = step_reg + SW'(1);
                    tbl_req.p_raddr = p;
                end
            end

            S_COMP_START:
            begin
                if (cur_reg == root_reg)
                begin
                    find_done = 1'b1;
                end
                else
                begin
                    // Read the old pointer and redirect the node in the same cycle
                    tbl_req.p_raddr = cur_reg;
                    tbl_req.p_we    = 1'b1;
                    tbl_req.p_waddr = cur_reg;
                    tbl_req.p_wdata = root_reg;
                    state_next      = S_COMP_CHK;
                end
            end

            S_COMP_CHK:
            begin
                if ((p == cur_reg) || (p == root_reg) || (step_reg == STEP_LAST))
                begin
                    find_done = 1'b1;
                end
                else
                begin
                    tbl_req.p_raddr = p;
                    tbl_req.p_we    = 1'b1;
                    tbl_req.p_waddr = p;
                    tbl_req.p_wdata = root_reg;
                    cur_next        = p;
                    step_next       = step_reg + SW'(1);
                end
            end

            S_RANK_A:
            begin
                tbl_req.r_raddr = xr_reg;
                state_next      = S_RANK_B;
            end

            S_RANK_B:
            begin
                rx_next         = tbl_rsp.rank;
                tbl_req.r_raddr = root_reg;
                state_next      = S_RANK_C;
            end

            S_RANK_C:
            begin
                // Link the lower-rank root under the higher one; on a tie root_b goes under root_a, whose rank rises
                tbl_req.p_we = 1'b1;
                if (rx_reg < ry)
                begin
                    tbl_req.p_waddr = xr_reg;
                    tbl_req.p_wdata = root_reg;
                    ra_next         = root_reg;
                end
                else
                begin
                    tbl_req.p_waddr = root_reg;
                    tbl_req.p_wdata = xr_reg;
                    if ((rx_reg == ry) && (rx_reg != RANK_MAX))
                    begin
                        tbl_req.r_we    = 1'b1;
                        tbl_req.r_waddr = xr_reg;
                        tbl_req.r_wdata = rx_reg + RANK_W'(1);
                    end
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                merged_next = 1'b1;
                state_next  = S_FINISH;
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hand over once a root is known and its path compressed
        if (find_done)
        begin
            if (!phase_reg)
            begin
                xr_next = root_reg;
                if (op_reg == OP_FIND)
                begin
                    ra_next    = root_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    v_next     = b_reg;
                    root_next  = b_reg;
                    phase_next = 1'b1;
                    step_next  = '0;
                    state_next = S_WALK_RD;
                end
            end
            else
            begin
                rb_next = root_reg;
                ra_next = xr_reg;
                if (xr_reg == root_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RANK_A;
                end
            end
        end
    end

    // Hold state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            op_reg     <= '0;
            b_reg      <= '0;
            v_reg      <= '0;
            root_reg   <= '0;
            cur_reg    <= '0;
            xr_reg     <= '0;
            phase_reg  <= 1'b0;
            step_reg   <= '0;
            rx_reg     <= '0;
            ra_reg     <= '0;
            rb_reg     <= '0;
            merged_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            op_reg     <= op_next;
            b_reg      <= b_next;
            v_reg      <= v_next;
            root_reg   <= root_next;
            cur_reg    <= cur_next;
            xr_reg     <= xr_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            rx_reg     <= rx_next;
            ra_reg     <= ra_next;
            rb_reg     <= rb_next;
            merged_reg <= merged_next;
        end
    end

    assign res.root_a    = ra_reg;
    assign res.root_b    = rb_reg;
    assign res.merged    = merged_reg;
    assign res.set_count = count_reg;

endmodule

@@ hw/rtl/disjoint_set_union_engine_top.sv @@
// Union-find engine with path compression and union by rank over a table of
// MAX_VERTICES vertices (up to 1024 addressable by the 10-bit node fields).
// Each input transaction carries one operation: make_set, find or union; every
// accepted transaction returns exactly one result. One item is worked at a time
// and s_axis_tready is low while it is in progress. make_set goes from
// acceptance straight to the finish state, which hands its result to the
// output register. A find walks the path to its root, reading one parent per
// cycle from the parent table's single read port, then the compression pass
// reads and rewrites each node on the path once more through the same port.
// A union does both walks and compressions, then, when the roots differ, two
// rank reads and the link; when they match it goes straight to finishing.
// Once a result is in the output register the sequencer is idle again and
// takes the next transaction; while that register is full and m_axis_tready
// is low it holds the result. Tables come up undefined; a vertex must see
// make_set before it is used. The output register lets the next transaction
// be accepted while a result still waits on m_axis_tready.
module disjoint_set_union_engine_top
    import dsu_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // opcode[1:0], node_a[11:2], node_b[21:12], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // root_a[9:0], root_b[19:10], merged[20],
                                        // set_count[31:21]
);

    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;
    dsu_res_t res;
    logic     res_valid;
    logic     res_ready;
    logic     out_valid_reg;
    dsu_res_t out_data_reg;

    dsu_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tdata[1:0]),
        .in_node_a (s_axis_tdata[11:2]),
        .in_node_b (s_axis_tdata[21:12]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .tbl_req   (tbl_req),
        .tbl_rsp   (tbl_rsp)
    );

    dsu_table #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_table (
        .clk (clk),
        .req (tbl_req),
        .rsp (tbl_rsp)
    );

    // Output register: load when empty or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sequencer ready in the cycle after a transaction");

    // Tables are written only while an item is in progress or being taken
    a_write_when_working: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_req.p_we || tbl_req.r_we) && s_axis_tready |-> s_axis_tvalid)
        else $error("table write with no item in progress");

    // A merge lowers a nonzero count, so a merged result never shows the ceiling
    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.merged |-> res.set_count != COUNT_MAX)
        else $error("merge reported with saturated set count");

    // A result is offered only while no new transaction can enter
    a_result_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_axis_tready)
        else $error("result offered while sequencer idle");

endmodule
